### sv/sha256_pkg.sv
package sha256_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = 8;
  localparam int BLK_WORDS  = 16;
  localparam int NUM_ROUNDS = 64;
  localparam int IN_W       = 64;
  localparam int OUT_W      = NUM_WORDS * WORD_W;
  localparam int POS_W      = $clog2(BLK_WORDS / 2);
  localparam int RND_W      = $clog2(NUM_ROUNDS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [RND_W-1:0]  rnd_t;

  localparam pos_t LAST_POS   = pos_t'(BLK_WORDS / 2 - 1);
  localparam rnd_t LAST_ROUND = rnd_t'(NUM_ROUNDS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD
  } state_t;

  localparam word_t INIT_HASH [NUM_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t big_sigma0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### sv/sha256_block_compression.sv
// Channel  Dir  tdata                               tuser
// s_axis   in   [63:0] message_bytes (byte 0 high)  [0] new_message
// m_axis   out  [255:0] hash_word_a..h, a lowest    none
//
// Items 0..6 of a block are only written into the schedule. Item 7 is
// written too, then the block runs 64 rounds through the single round unit
// and adds the result into the chaining value, with input held not ready.
// Reset loads the standard initial hash value and clears the item position.
// The result sits in an output register; the block takes new items while it
// waits, and only the final add stalls if the previous result is still held.
module sha256_block_compression
  import sha256_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // [63:0] message_bytes
  input  logic             s_axis_tuser,   // [0] new_message
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // [31:0] hash_word_a .. [255:224] hash_word_h
);

  state_t state, state_next;
  pos_t   pos;
  rnd_t   round_cnt;
  word_t  chain     [NUM_WORDS];
  word_t  work      [NUM_WORDS];
  word_t  sched     [BLK_WORDS];
  word_t  out_word  [NUM_WORDS];
  word_t  chain_sum [NUM_WORDS];

  logic  in_xfer;
  logic  out_free;
  pos_t  pos_eff;
  word_t t1, t2, ch, maj, w_new;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign pos_eff       = s_axis_tuser ? '0 : pos;

  // Round unit, schedule extension, chaining sum and output packing
  always_comb begin
    ch    = (work[4] & work[5]) ^ (~work[4] & work[6]);
    maj   = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t1    = work[7] + big_sigma1(work[4]) + ch + ROUND_K[round_cnt] + sched[0];
    t2    = big_sigma0(work[0]) + maj;
    w_new = small_sigma1(sched[14]) + sched[9] + small_sigma0(sched[1]) + sched[0];
    for (int i = 0; i < NUM_WORDS; i++) begin
      chain_sum[i]                   = chain[i] + work[i];
      m_axis_tdata[i*WORD_W +: WORD_W] = out_word[i];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer && pos_eff == LAST_POS) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_cnt == LAST_ROUND) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pos           <= '0;
      round_cnt     <= '0;
      m_axis_tvalid <= 1'b0;
      chain         <= INIT_HASH;
    end else begin
      state <= state_next;
      if (state == ST_ADD && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          round_cnt <= '0;
          if (in_xfer) begin
            if (s_axis_tuser) chain <= INIT_HASH;
            pos <= (pos_eff == LAST_POS) ? '0 : pos_eff + 1'b1;
          end
        end
        ST_ROUND: begin
          round_cnt <= round_cnt + 1'b1;
        end
        ST_ADD: begin
          if (out_free) chain <= chain_sum;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          sched[{pos_eff, 1'b0}] <= s_axis_tdata[IN_W-1:WORD_W];
          sched[{pos_eff, 1'b1}] <= s_axis_tdata[WORD_W-1:0];
          // last item never carries a reload, so the current chain is right
          if (pos_eff == LAST_POS) work <= chain;
        end
      end
      ST_ROUND: begin
        work[7] <= work[6];
        work[6] <= work[5];
        work[5] <= work[4];
        work[4] <= work[3] + t1;
        work[3] <= work[2];
        work[2] <= work[1];
        work[1] <= work[0];
        work[0] <= t1 + t2;
        for (int i = 0; i < BLK_WORDS - 1; i++) sched[i] <= sched[i+1];
        sched[BLK_WORDS-1] <= w_new;
      end
      ST_ADD: begin
        if (out_free) out_word <= chain_sum;
      end
      default: ;
    endcase
  end

endmodule

### sv/sha256_checker.sv
module sha256_checker
  import sha256_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // held result must not change or vanish
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("reset did not leave block ready and empty");

  // busy only after an accepted transaction without new_message
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready && !s_axis_tuser))
    else $error("input stalled without a completing transaction");

  // first item of a new message never starts a compression
  a_new_msg_no_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> s_axis_tready)
    else $error("new message item started a compression");

  a_result_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result presented while still compressing");

endmodule

bind sha256_block_compression sha256_checker u_sha256_checker (.*);
